// ===== hw/rtl/lgss_pkg.sv =====
`timescale 1ns / 1ps

package lgss_pkg;

	localparam int MAX_SPAN    = 64;
	localparam int INDEX_BITS  = 8;
	localparam int ROW_ENTRIES = 257;

	localparam int FRAC_BITS   = 16 - INDEX_BITS;
	localparam int TABLE_DEPTH = 2 * ROW_ENTRIES;
	localparam int IDX_W       = $clog2(ROW_ENTRIES);
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int XW          = (IDX_W > INDEX_BITS + 1) ? IDX_W : INDEX_BITS + 1;
	localparam int LEN_W       = $clog2(MAX_SPAN + 1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SPAN = 1'b1;

	localparam logic CFG_TILE_MODE = 1'b0;
	localparam logic CFG_NEAR_ZERO = 1'b1;

	localparam logic [1:0] TILE_CLAMP  = 2'd0;
	localparam logic [1:0] TILE_REPEAT = 2'd1;
	localparam logic [1:0] TILE_MIRROR = 2'd2;

	localparam logic [15:0] LIMIT_RESET = 16'd16;
	localparam logic [7:0]  BYTE_MAX    = 8'hFF;
	localparam logic [31:0] CLAMP_END   = 32'h0000_FFFF;
	localparam logic [31:0] FRAC_MASK   = 32'((64'd1 << FRAC_BITS) - 64'd1);

	typedef logic [15:0] prod_t [4];

	function automatic logic [XW-1:0] step_index(logic [31:0] pos, logic [1:0] mode);
		logic [INDEX_BITS:0]   v;
		logic [INDEX_BITS-1:0] m;
		logic [XW-1:0]         r;
		v = pos[16:FRAC_BITS];
		m = ~v[INDEX_BITS-1:0];
		case (mode)
			TILE_CLAMP: begin
				if (pos[31]) r = '0;
				else if (pos >= CLAMP_END) r = XW'(ROW_ENTRIES - 1);
				else r = XW'(pos[15:FRAC_BITS]);
			end
			TILE_MIRROR: r = v[INDEX_BITS] ? XW'(m) : XW'(v[INDEX_BITS-1:0]);
			default: r = XW'(v[INDEX_BITS-1:0]);
		endcase
		return r;
	endfunction

	function automatic logic [15:0] tile_unit(logic [31:0] pos, logic [1:0] mode);
		logic [15:0] r;
		case (mode)
			TILE_CLAMP: begin
				if (pos[31]) r = '0;
				else if (pos > CLAMP_END) r = 16'hFFFF;
				else r = pos[15:0];
			end
			TILE_MIRROR: r = pos[16] ? ~pos[15:0] : pos[15:0];
			default: r = pos[15:0];
		endcase
		return r;
	endfunction

	function automatic logic [7:0] lerp_weight(logic [15:0] unit);
		logic [31:0] t;
		t = {16'b0, unit} & FRAC_MASK;
		t = (t << 8) >> FRAC_BITS;
		return t[7:0];
	endfunction

	function automatic logic [IDX_W-1:0] clamp_index(logic [XW-1:0] x);
		if (x >= XW'(ROW_ENTRIES - 1)) return IDX_W'(ROW_ENTRIES - 1);
		return x[IDX_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] table_addr(logic row, logic [IDX_W-1:0] idx);
		return row ? ADDR_W'(ROW_ENTRIES) + ADDR_W'(idx) : ADDR_W'(idx);
	endfunction

endpackage

// ===== hw/rtl/linear_gradient_span_shader_unit.sv =====
// Linear gradient span shader.
// The input channel (in_valid / in_stall) takes two kinds of beat. A load beat
// writes one colour into the two-row table; a span beat shades span_length
// pixels, one output beat per pixel, with last_pixel set on the final one.
// Configuration (cfg_write / cfg_index / cfg_data) is to be written only while
// idle; the block does not enforce this. A span beat raises in_stall while its
// sequencer issues one pixel per cycle, unless out_stall holds it, into a
// five-stage pipeline (address, table read, products, sum) that reads the table
// memory once per pixel on two ports; its length saturates at 64. A load beat or
// a zero-length span does not hold the input after it is taken. The first pixel
// passes s1 to s5 to out_valid, then one follows every cycle unless stalled.
// While out_stall holds a waiting beat, the whole pipeline and sequencer
// freeze and in_stall is raised; nothing is lost or repeated.
// Reset clears the sequencer, the stage valid bits and the configuration
// (clamp mode, limit 16). The colour table is not cleared and must be loaded
// before use.
`timescale 1ns / 1ps

module linear_gradient_span_shader_unit
	import lgss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic               load_row,
	input  logic [8:0]         load_index,
	input  logic [31:0]        load_color,
	input  logic signed [31:0] start_pos,
	input  logic signed [31:0] step,
	input  logic               dither_phase,
	input  logic [6:0]         span_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        pixel_color,
	output logic               last_pixel,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	logic [1:0]       tile_mode_q;
	logic [15:0]      limit_q;
	logic             busy_q;
	logic [LEN_W-1:0] left_q;
	logic [31:0]      pos_q;
	logic [31:0]      step_q;
	logic             row_q;
	logic             vert_q;

	logic        v_s1, load_s1, row_s1, last_s1, vert_s1;
	logic [31:0] pos_s1;
	logic [8:0]  lidx_s1;
	logic [31:0] lcolor_s1;

	logic              v_s2, load_s2, wr_ok_s2, last_s2, vert_s2;
	logic [ADDR_W-1:0] addr_a_s2, addr_b_s2;
	logic [7:0]        w_s2;
	logic [31:0]       lcolor_s2;

	logic        v_s3, last_s3, vert_s3;
	logic [31:0] rd_a_s3, rd_b_s3;
	logic [7:0]  w_s3;

	logic        v_s4, last_s4, vert_s4;
	logic [31:0] color_s4;
	prod_t       ph_s4, pl_s4;

	logic        v_s5, last_s5;
	logic [31:0] color_s5;

	logic [31:0] color_mem [TABLE_DEPTH];

	logic             adv, in_acc, near;
	logic [31:0]      dx, mag;
	logic [LEN_W-1:0] span_len;
	logic [15:0]      unit;
	logic [XW-1:0]    idx_lo, idx_hi, sidx;
	logic [ADDR_W-1:0] addr_a, addr_b;
	prod_t            ph, pl;
	logic [31:0]      lerp_color;

	assign adv      = !v_s5 || !out_stall;
	assign in_stall = busy_q || !adv;
	assign in_acc   = in_valid && !in_stall;

	assign dx       = step;
	assign mag      = dx[31] ? (32'd0 - dx) : dx;
	assign near     = mag <= {16'b0, limit_q};
	assign span_len = (span_length > 7'(MAX_SPAN)) ? LEN_W'(MAX_SPAN) : LEN_W'(span_length);

	always_comb begin
		unit   = tile_unit(pos_s1, tile_mode_q);
		idx_lo = XW'(unit[15:FRAC_BITS]);
		idx_hi = idx_lo + XW'(1);
		sidx   = step_index(pos_s1, tile_mode_q);
		if (load_s1) begin
			addr_a = table_addr(row_s1, IDX_W'(lidx_s1));
		end else if (vert_s1) begin
			addr_a = table_addr(row_s1, clamp_index(idx_lo));
		end else begin
			addr_a = table_addr(row_s1, clamp_index(sidx));
		end
		addr_b = table_addr(row_s1, clamp_index(idx_hi));
	end

	always_comb begin
		logic [8:0]  sc;
		logic [7:0]  dc;
		logic [16:0] a, b;
		sc = {1'b0, w_s3} + 9'd1;
		dc = BYTE_MAX - w_s3;
		for (int i = 0; i < 4; i++) begin
			a = rd_b_s3[8*i +: 8] * sc;
			b = rd_a_s3[8*i +: 8] * dc;
			ph[i] = a[15:0];
			pl[i] = b[15:0];
		end
	end

	always_comb begin
		logic [15:0] s;
		for (int i = 0; i < 4; i++) begin
			s = ph_s4[i] + pl_s4[i];
			lerp_color[8*i +: 8] = s[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_mode_q <= TILE_CLAMP;
			limit_q     <= LIMIT_RESET;
			busy_q      <= 1'b0;
			left_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_TILE_MODE: tile_mode_q <= cfg_data[1:0];
					CFG_NEAR_ZERO: limit_q <= cfg_data;
				endcase
			end
			if (adv) begin
				if (busy_q) begin
					left_q <= left_q - LEN_W'(1);
					busy_q <= left_q != LEN_W'(1);
				end else if (in_acc && operation == OP_SPAN) begin
					left_q <= span_len;
					busy_q <= span_len != '0;
				end
				v_s1 <= busy_q || (in_acc && operation == OP_LOAD);
				v_s2 <= v_s1;
				v_s3 <= v_s2 && !load_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				pos_q <= pos_q + step_q;
				row_q <= ~row_q;
			end else if (in_acc) begin
				pos_q  <= start_pos;
				step_q <= near ? 32'd0 : dx;
				row_q  <= dither_phase;
				vert_q <= near;
			end

			load_s1   <= !busy_q;
			pos_s1    <= pos_q;
			row_s1    <= busy_q ? row_q : load_row;
			last_s1   <= left_q == LEN_W'(1);
			vert_s1   <= vert_q;
			lidx_s1   <= load_index;
			lcolor_s1 <= load_color;

			load_s2   <= load_s1;
			wr_ok_s2  <= 32'(lidx_s1) < 32'(ROW_ENTRIES);
			addr_a_s2 <= addr_a;
			addr_b_s2 <= addr_b;
			w_s2      <= lerp_weight(unit);
			last_s2   <= last_s1;
			vert_s2   <= vert_s1;
			lcolor_s2 <= lcolor_s1;

			w_s3    <= w_s2;
			last_s3 <= last_s2;
			vert_s3 <= vert_s2;

			ph_s4    <= ph;
			pl_s4    <= pl;
			color_s4 <= rd_a_s3;
			last_s4  <= last_s3;
			vert_s4  <= vert_s3;

			color_s5 <= vert_s4 ? lerp_color : color_s4;
			last_s5  <= last_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s2 && load_s2 && wr_ok_s2) begin
				color_mem[addr_a_s2] <= lcolor_s2;
			end
			rd_a_s3 <= color_mem[addr_a_s2];
			rd_b_s3 <= color_mem[addr_b_s2];
		end
	end

	assign out_valid   = v_s5;
	assign pixel_color = color_s5;
	assign last_pixel  = last_s5;

`ifndef SYNTHESIS
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (left_q != '0 && left_q <= LEN_W'(MAX_SPAN)))
		else $error("span counter out of range while busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !load_s1 && last_s1) |-> !busy_q)
		else $error("sequencer still busy after issuing the last pixel");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && out_stall) |=> (v_s5 && $stable(color_s5) && $stable(left_q)))
		else $error("pipeline moved while the output beat was stalled");

	a_load_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && load_s2) |=> !v_s3)
		else $error("load beat passed the table stage");
`endif

endmodule
